// ===== src/mi3_pkg.sv =====
// Shared types and cofactor index tables for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

  // Element index (row*3+col) of the two factors of each cofactor product
  localparam int MI3_PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int MI3_PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int MI3_NA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int MI3_NB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // Determinant status that travels from the front end to the lanes
  typedef struct packed {
    logic zero;
    logic dneg;
  } mi3_side_t;

  // Per-item flags inside a divide lane
  typedef struct packed {
    logic zero;
    logic neg;
    logic ovf;
  } mi3_lflag_t;

endpackage

// ===== src/mi3_front.sv =====
// Front end: cofactor products, cofactors and determinant, five register stages.
`timescale 1ns / 1ps
module mi3_front import mi3_pkg::*; #(
  parameter int EW = 16
) (
  input  logic                   clk,
  input  logic signed [EW-1:0]   a_i   [9],
  output logic signed [2*EW:0]   cof_o [9],
  output logic signed [3*EW+2:0] det_o,
  output mi3_side_t              side_o
);

  localparam int CW = 2 * EW + 1;
  localparam int DW = 3 * EW + 3;
  localparam int PW = EW + CW;

  logic signed [EW-1:0]   a_r   [9];
  logic signed [2*EW-1:0] pp_r  [9];
  logic signed [2*EW-1:0] pn_r  [9];
  logic signed [EW-1:0]   a0b_r [3];
  logic signed [EW-1:0]   a0c_r [3];
  logic signed [CW-1:0]   cofc_r [9];
  logic signed [CW-1:0]   cofd_r [9];
  logic signed [CW-1:0]   cofe_r [9];
  logic signed [PW-1:0]   dp_r  [3];
  logic signed [DW-1:0]   det_nxt;
  logic signed [DW-1:0]   det_r;
  mi3_side_t              side_r;

  // Stage A: capture elements
  always_ff @(posedge clk) begin
    a_r <= a_i;
  end

  // Stage B: the eighteen 2x2 minor products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      pp_r[k] <= a_r[MI3_PA[k]] * a_r[MI3_PB[k]];
      pn_r[k] <= a_r[MI3_NA[k]] * a_r[MI3_NB[k]];
    end
    for (int j = 0; j < 3; j++) a0b_r[j] <= a_r[j];
  end

  // Stage C: cofactors
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) cofc_r[k] <= CW'(pp_r[k]) - CW'(pn_r[k]);
    a0c_r <= a0b_r;
  end

  // Stage D: row-0 expansion products
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) dp_r[j] <= a0c_r[j] * cofc_r[3*j];
    cofd_r <= cofc_r;
  end

  // Stage E: determinant sum and status
  assign det_nxt = DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);

  always_ff @(posedge clk) begin
    det_r       <= det_nxt;
    side_r.zero <= (det_nxt == '0);
    side_r.dneg <= det_nxt[DW-1];
    cofe_r      <= cofd_r;
  end

  assign cof_o  = cofe_r;
  assign det_o  = det_r;
  assign side_o = side_r;

endmodule

// ===== src/mi3_div_lane.sv =====
// One divide lane: cofactor / determinant, restoring, one quotient bit per stage.
`timescale 1ns / 1ps
module mi3_div_lane import mi3_pkg::*; #(
  parameter int EW = 16,
  parameter int EF = 12,
  parameter int OW = 32,
  parameter int OF = 16
) (
  input  logic                   clk,
  input  logic signed [2*EW:0]   cof_i,
  input  logic signed [3*EW+2:0] det_i,
  input  mi3_side_t              side_i,
  output logic [OW-1:0]          q_o
);

  localparam int CW  = 2 * EW + 1;
  localparam int DW  = 3 * EW + 3;
  localparam int S   = OF + EF;
  localparam int NW  = CW + S;
  localparam int NWX = (NW > OW) ? NW : OW + 1;
  localparam int HW  = NWX - OW;
  localparam int RW  = ((HW > DW) ? HW : DW) + 1;

  // L1: magnitudes and numerator
  logic [NWX-1:0] num_r;
  logic [DW-1:0]  dm1_r;
  mi3_lflag_t     fl1_r;
  logic [CW-1:0]  cm;
  logic [DW-1:0]  dm;

  assign cm = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
  assign dm = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

  always_ff @(posedge clk) begin
    num_r     <= NWX'(cm) << S;
    dm1_r     <= dm;
    fl1_r.zero <= side_i.zero;
    fl1_r.neg  <= cof_i[CW-1] ^ side_i.dneg;
    fl1_r.ovf  <= 1'b0;
  end

  // Division stage arrays; index 0 is the L2 register
  logic [RW-1:0] rem_s [OW+1];
  logic [OW-1:0] q_s   [OW+1];
  logic [OW-1:0] lo_s  [OW+1];
  logic [DW-1:0] dm_s  [OW+1];
  mi3_lflag_t    fl_s  [OW+1];
  logic [RW-1:0] rem0;

  // L2: high part of numerator; quotient overflows if it already reaches the divisor
  assign rem0 = RW'(num_r >> OW);

  always_ff @(posedge clk) begin
    rem_s[0]     <= rem0;
    q_s[0]       <= '0;
    lo_s[0]      <= num_r[OW-1:0];
    dm_s[0]      <= dm1_r;
    fl_s[0].zero <= fl1_r.zero;
    fl_s[0].neg  <= fl1_r.neg;
    fl_s[0].ovf  <= (rem0 >= RW'(dm1_r));
  end

  // One quotient bit per stage
  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [RW-1:0] rem_t;
    logic          ge;
    assign rem_t = {rem_s[k][RW-2:0], lo_s[k][OW-1]};
    assign ge    = (rem_t >= RW'(dm_s[k]));
    always_ff @(posedge clk) begin
      rem_s[k+1] <= ge ? rem_t - RW'(dm_s[k]) : rem_t;
      q_s[k+1]   <= {q_s[k][OW-2:0], ge};
      lo_s[k+1]  <= {lo_s[k][OW-2:0], 1'b0};
      dm_s[k+1]  <= dm_s[k];
      fl_s[k+1]  <= fl_s[k];
    end
  end

  // Saturate, apply sign, zero on singular
  localparam logic [OW-1:0] LIM = OW'(1) << (OW - 1);
  logic [OW-1:0] qf;
  logic [OW-1:0] mag;
  logic [OW-1:0] res_r;

  assign qf = q_s[OW];

  always_comb begin
    if (fl_s[OW].neg) begin
      mag = (fl_s[OW].ovf || qf > LIM) ? LIM : qf;
    end else begin
      mag = (fl_s[OW].ovf || qf > LIM - OW'(1)) ? LIM - OW'(1) : qf;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_s[OW].zero) begin
      res_r <= '0;
    end else begin
      res_r <= fl_s[OW].neg ? (~mag + OW'(1)) : mag;
    end
  end

  assign q_o = res_r;

endmodule

// ===== src/matrix3x3_inverse.sv =====
// Items pass the front end, then each lane's L1, L2, quotient-bit and output registers.
// Throughput: one item per cycle; busy stays low, set by nine fully pipelined divide lanes
// of one restoring stage per quotient bit.
// Reset (rst_n, synchronous, active low) clears the valid pipeline; data regs are not reset.
// Results appear for one cycle with out_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int ELEM_WIDTH = 16,
  parameter int ELEM_FRAC  = 12,
  parameter int OUT_WIDTH  = 32,
  parameter int OUT_FRAC   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [ELEM_WIDTH-1:0]   in_a00,
  input  logic signed [ELEM_WIDTH-1:0]   in_a01,
  input  logic signed [ELEM_WIDTH-1:0]   in_a02,
  input  logic signed [ELEM_WIDTH-1:0]   in_a10,
  input  logic signed [ELEM_WIDTH-1:0]   in_a11,
  input  logic signed [ELEM_WIDTH-1:0]   in_a12,
  input  logic signed [ELEM_WIDTH-1:0]   in_a20,
  input  logic signed [ELEM_WIDTH-1:0]   in_a21,
  input  logic signed [ELEM_WIDTH-1:0]   in_a22,
  output logic                           out_valid,
  output logic signed [OUT_WIDTH-1:0]    out_inv_00,
  output logic signed [OUT_WIDTH-1:0]    out_inv_01,
  output logic signed [OUT_WIDTH-1:0]    out_inv_02,
  output logic signed [OUT_WIDTH-1:0]    out_inv_10,
  output logic signed [OUT_WIDTH-1:0]    out_inv_11,
  output logic signed [OUT_WIDTH-1:0]    out_inv_12,
  output logic signed [OUT_WIDTH-1:0]    out_inv_20,
  output logic signed [OUT_WIDTH-1:0]    out_inv_21,
  output logic signed [OUT_WIDTH-1:0]    out_inv_22,
  output logic signed [3*ELEM_WIDTH+2:0] out_determinant,
  output logic                           out_singular
);

  localparam int CW  = 2 * ELEM_WIDTH + 1;
  localparam int DW  = 3 * ELEM_WIDTH + 3;
  localparam int LL  = OUT_WIDTH + 3;
  localparam int LAT = LL + 5;

  logic                          accept;
  logic signed [ELEM_WIDTH-1:0]  a    [9];
  logic signed [CW-1:0]          cof  [9];
  logic signed [DW-1:0]          det;
  mi3_side_t                     side;
  logic [OUT_WIDTH-1:0]          q    [9];
  logic [LAT-1:0]                v_r;
  logic signed [DW-1:0]          detp_r [LL];
  logic [LL-1:0]                 sing_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign a = '{in_a00, in_a01, in_a02, in_a10, in_a11, in_a12, in_a20, in_a21, in_a22};

  mi3_front #(.EW(ELEM_WIDTH)) u_front (
    .clk    (clk),
    .a_i    (a),
    .cof_o  (cof),
    .det_o  (det),
    .side_o (side)
  );

  // Nine divide lanes, one per inverse element
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div_lane #(
      .EW (ELEM_WIDTH),
      .EF (ELEM_FRAC),
      .OW (OUT_WIDTH),
      .OF (OUT_FRAC)
    ) u_lane (
      .clk    (clk),
      .cof_i  (cof[k]),
      .det_i  (det),
      .side_i (side),
      .q_o    (q[k])
    );
  end

  // Item valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-2:0], accept};
    end
  end

  // Determinant and singular flag ride alongside the lanes
  always_ff @(posedge clk) begin
    detp_r[0] <= det;
    sing_r    <= {sing_r[LL-2:0], side.zero};
    for (int i = 1; i < LL; i++) detp_r[i] <= detp_r[i-1];
  end

  // Merge lane results into the result item
  assign out_valid       = v_r[LAT-1];
  assign out_inv_00      = q[0];
  assign out_inv_01      = q[1];
  assign out_inv_02      = q[2];
  assign out_inv_10      = q[3];
  assign out_inv_11      = q[4];
  assign out_inv_12      = q[5];
  assign out_inv_20      = q[6];
  assign out_inv_21      = q[7];
  assign out_inv_22      = q[8];
  assign out_determinant = detp_r[LL-1];
  assign out_singular    = sing_r[LL-1];

  // Every accepted item gives a result strobe after the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted item produced no result strobe");

  // Every result strobe traces back to an accepted item
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without an accepted item");

  // Singular flag agrees with the delivered determinant
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_singular == (out_determinant == '0)))
    else $error("singular flag disagrees with determinant");

  // Singular matrices give a zero inverse, checked on the diagonal elements
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_inv_00 == '0 && out_inv_11 == '0 && out_inv_22 == '0))
    else $error("singular item with nonzero inverse");

endmodule
